@@ src/urg_pkg.sv @@
// Shared types, codes and helper function of the underline rectangle generator.
package urg_pkg;

    // Underline style codes as they arrive on the input
    localparam logic [2:0] STYLE_PLAIN  = 3'd0;
    localparam logic [2:0] STYLE_DOUBLE = 3'd1;
    localparam logic [2:0] STYLE_CURLY  = 3'd2;
    localparam logic [2:0] STYLE_DOTTED = 3'd3;
    localparam logic [2:0] STYLE_DASHED = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_SCALE  = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    localparam int CFG_DATA_W = 11;

    // Reset values of the configuration registers
    localparam logic [3:0]  RST_SCALE  = 4'd1;
    localparam logic [9:0]  RST_WIDTH  = 10'd8;
    localparam logic [10:0] RST_HEIGHT = 11'd16;

    // Drawing modes after classification
    typedef enum logic [1:0] {
        MD_PLAIN,
        MD_DOUBLE,
        MD_CURLY,
        MD_PIECES
    } t_mode;

    // Back end sequencer states
    typedef enum logic {
        BS_IDLE,
        BS_RUN
    } t_bstate;

    // Classified command handed from the front to the back
    typedef struct packed {
        t_mode       mode;
        logic [15:0] x;
        logic [15:0] base;
        logic [9:0]  cw;
        logic [3:0]  s;
        logic [6:0]  step;
        logic [5:0]  pw;
        logic [23:0] ink;
    } t_cmd;

    // One output rectangle
    typedef struct packed {
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] width;
        logic [15:0] height;
        logic [23:0] ink;
        logic        last;
    } t_rect;

    // Wave offset of one step: table value times scale, halved toward zero
    function automatic logic signed [4:0] wave_off(input logic [2:0] ph,
                                                   input logic [3:0] s);
        logic [4:0] half;
        logic [4:0] whole;
        logic [4:0] res;
        half  = {2'b00, s[3:1]};
        whole = {1'b0, s};
        case (ph) inside
            3'd1, 3'd3: res = half;
            3'd2:       res = whole;
            3'd5, 3'd7: res = 5'd0 - half;
            3'd6:       res = 5'd0 - whole;
            default:    res = 5'd0;
        endcase
        return signed'(res);
    endfunction

endpackage

@@ src/urg_front.sv @@
// Front end: configuration registers, item classification and command queue.
module urg_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [urg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic signed [15:0]             i_origin_x,
    input  logic signed [15:0]             i_origin_y,
    input  logic [2:0]                     i_line_style,
    input  logic [23:0]                    i_ink_rgb,
    output logic                           o_cmd_valid,
    output urg_pkg::t_cmd                  o_cmd,
    input  logic                           i_cmd_pop
);

    logic [3:0]    r_scale;
    logic [9:0]    r_width;
    logic [10:0]   r_height;

    urg_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    logic [3:0]    s;
    logic [9:0]    smax;
    logic [9:0]    cw;
    logic [15:0]   base;
    urg_pkg::t_cmd cmd;
    logic          keep;
    logic          accept;
    logic          do_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= urg_pkg::RST_SCALE;
            r_width  <= urg_pkg::RST_WIDTH;
            r_height <= urg_pkg::RST_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                urg_pkg::CFG_SCALE:  r_scale  <= i_cfg_data[3:0];
                urg_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[9:0];
                urg_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Classify the incoming item
    always_comb begin
        s    = (r_scale == 4'd0) ? 4'd1 : r_scale;
        smax = {s, 6'b000000};
        cw   = (r_width > smax) ? smax : r_width;
        base = 16'(i_origin_y) + {5'b00000, r_height} - {11'd0, s, 1'b0};

        cmd.x    = 16'(i_origin_x);
        cmd.base = base;
        cmd.cw   = cw;
        cmd.s    = s;
        cmd.ink  = i_ink_rgb;
        cmd.mode = urg_pkg::MD_PLAIN;
        cmd.step = {3'b000, s};
        cmd.pw   = {2'b00, s};
        keep     = 1'b1;
        unique case (i_line_style)
            urg_pkg::STYLE_DOUBLE: cmd.mode = urg_pkg::MD_DOUBLE;
            urg_pkg::STYLE_CURLY: begin
                cmd.mode = urg_pkg::MD_CURLY;
                keep     = (cw != 10'd0);
            end
            urg_pkg::STYLE_DOTTED: begin
                cmd.mode = urg_pkg::MD_PIECES;
                cmd.step = {2'b00, s, 1'b0};
                keep     = (cw != 10'd0);
            end
            urg_pkg::STYLE_DASHED: begin
                cmd.mode = urg_pkg::MD_PIECES;
                cmd.step = {1'b0, s, 2'b00} + {2'b00, s, 1'b0};
                cmd.pw   = {1'b0, s, 1'b0} + {2'b00, s};
                keep     = (cw != 10'd0);
            end
            default: cmd.mode = urg_pkg::MD_PLAIN;
        endcase
    end

    assign o_full      = (r_cnt == 2'd2);
    assign accept      = i_push && !o_full;
    // Drop curly, dotted and dashed items in a zero-width cell
    assign do_push     = accept && keep;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, i_cmd_pop};
        end
    end

endmodule

@@ src/urg_outq.sv @@
// Two-entry result queue that parts the back end from the result consumer.
module urg_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  urg_pkg::t_rect i_rect,
    output logic           o_full,
    output logic           o_empty,
    input  logic           i_pop,
    output urg_pkg::t_rect o_rect
);

    urg_pkg::t_rect r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_rect  = r_q[r_rp];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_rect;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, do_pop};
        end
    end

endmodule

@@ src/urg_back.sv @@
// Back end: sequencer that walks one command and emits its rectangles.
module urg_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  urg_pkg::t_cmd  i_cmd,
    output logic           o_cmd_pop,
    input  logic           i_oq_full,
    output logic           o_rect_push,
    output urg_pkg::t_rect o_rect
);

    urg_pkg::t_bstate   r_state;
    urg_pkg::t_bstate   n_state;
    urg_pkg::t_cmd      r_cmd;
    urg_pkg::t_cmd      n_cmd;
    logic [10:0]        r_col;
    logic [10:0]        n_col;
    logic [10:0]        r_run;
    logic [10:0]        n_run;
    logic [2:0]         r_phase;
    logic [2:0]         n_phase;

    logic [10:0]        ncol;
    logic               at_end;
    logic signed [4:0]  off_k;
    logic signed [4:0]  off_n;
    logic [10:0]        run_end;
    logic [15:0]        height;

    always_comb begin
        ncol    = r_col + {4'd0, r_cmd.step};
        at_end  = (ncol >= {1'b0, r_cmd.cw});
        off_k   = urg_pkg::wave_off(r_phase, r_cmd.s);
        off_n   = urg_pkg::wave_off(r_phase + 3'd1, r_cmd.s);
        run_end = at_end ? {1'b0, r_cmd.cw} : ncol;
        height  = {12'd0, r_cmd.s};
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_col       = r_col;
        n_run       = r_run;
        n_phase     = r_phase;
        o_cmd_pop   = 1'b0;
        o_rect_push = 1'b0;

        o_rect.left   = r_cmd.x;
        o_rect.top    = r_cmd.base;
        o_rect.width  = {6'd0, r_cmd.cw};
        o_rect.height = height;
        o_rect.ink    = r_cmd.ink;
        o_rect.last   = 1'b1;

        unique case (r_state)
            urg_pkg::BS_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_col     = 11'd0;
                    n_run     = 11'd0;
                    n_phase   = 3'd0;
                    n_state   = urg_pkg::BS_RUN;
                end
            end
            urg_pkg::BS_RUN: begin
                if (!i_oq_full) begin
                    unique case (r_cmd.mode)
                        urg_pkg::MD_PLAIN: begin
                            o_rect_push = 1'b1;
                            n_state     = urg_pkg::BS_IDLE;
                        end
                        urg_pkg::MD_DOUBLE: begin
                            o_rect_push = 1'b1;
                            // Upper line first, then the base line
                            if (r_col == 11'd0) begin
                                o_rect.top  = r_cmd.base - {11'd0, r_cmd.s, 1'b0};
                                o_rect.last = 1'b0;
                                n_col       = 11'd1;
                            end else begin
                                n_state = urg_pkg::BS_IDLE;
                            end
                        end
                        urg_pkg::MD_PIECES: begin
                            o_rect_push  = 1'b1;
                            o_rect.left  = r_cmd.x + {5'd0, r_col};
                            o_rect.width = {10'd0, r_cmd.pw};
                            o_rect.last  = at_end;
                            n_col        = ncol;
                            if (at_end) begin
                                n_state = urg_pkg::BS_IDLE;
                            end
                        end
                        default: begin
                            // Curly: one step per unstalled cycle; close run on change
                            o_rect.left  = r_cmd.x + {5'd0, r_run};
                            o_rect.top   = r_cmd.base - height
                                           - {{11{off_k[4]}}, off_k};
                            o_rect.width = {5'd0, run_end - r_run};
                            o_rect.last  = at_end;
                            o_rect_push  = at_end || (off_k != off_n);
                            n_col        = ncol;
                            n_phase      = r_phase + 3'd1;
                            if (o_rect_push) begin
                                n_run = ncol;
                            end
                            if (at_end) begin
                                n_state = urg_pkg::BS_IDLE;
                            end
                        end
                    endcase
                end
            end
            default: n_state = urg_pkg::BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= urg_pkg::BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_col   <= n_col;
        r_run   <= n_run;
        r_phase <= n_phase;
    end

endmodule

@@ src/underline_rect_generator.sv @@
// Top level of the underline rectangle generator.
//
// Usage: write pixel_scale, cell_width_px and cell_height_px through the
// configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) while the block is
// idle. Push items (origin, style, ink) with i_push while o_full is low;
// pop rectangles with i_pop while o_empty is low. The last rectangle of an
// item carries o_last_rect. Curly, dotted and dashed items in a zero-width
// cell yield no rectangle at all.
//
// Flow: a pushed item is registered in the command queue; an idle sequencer
// loads it, then plain, double, dotted and dashed push a rectangle once the
// result queue has room, curly only once its first run closes. One command at a
// time; while the result queue has room: one rectangle per cycle for plain (1),
// double (2), dotted and dashed; one wave step per cycle for curly, in all
// ceil(width/scale), at most 64. Two-entry command and result queues flank it.
//
// Reset (synchronous, active low) empties both queues, idles the sequencer
// and restores the configuration to scale 1, width 8, height 16. When the
// consumer stalls, the result queue fills and the sequencer holds; the
// command queue then fills and o_full rises.
module underline_rect_generator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [urg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic signed [15:0]             i_origin_x,
    input  logic signed [15:0]             i_origin_y,
    input  logic [2:0]                     i_line_style,
    input  logic [23:0]                    i_ink_rgb,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic signed [15:0]             o_rect_left,
    output logic signed [15:0]             o_rect_top,
    output logic [15:0]                    o_rect_width,
    output logic [15:0]                    o_rect_height,
    output logic [23:0]                    o_rect_ink,
    output logic                           o_last_rect
);

    logic           cmd_valid;
    urg_pkg::t_cmd  cmd;
    logic           cmd_pop;
    logic           oq_full;
    logic           rect_push;
    urg_pkg::t_rect rect_in;
    urg_pkg::t_rect rect_out;

    // Classify items and hold them until the sequencer is free
    urg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_origin_x   (i_origin_x),
        .i_origin_y   (i_origin_y),
        .i_line_style (i_line_style),
        .i_ink_rgb    (i_ink_rgb),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_pop    (cmd_pop)
    );

    // Walk each command and produce its rectangles
    urg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_oq_full   (oq_full),
        .o_rect_push (rect_push),
        .o_rect      (rect_in)
    );

    // Buffer rectangles toward the consumer
    urg_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rect_push),
        .i_rect  (rect_in),
        .o_full  (oq_full),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_rect  (rect_out)
    );

    assign o_rect_left   = signed'(rect_out.left);
    assign o_rect_top    = signed'(rect_out.top);
    assign o_rect_width  = rect_out.width;
    assign o_rect_height = rect_out.height;
    assign o_rect_ink    = rect_out.ink;
    assign o_last_rect   = rect_out.last;

endmodule

@@ src/urg_checker.sv @@
// Port-level assertions for the underline rectangle generator and their binding.
module urg_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_full,
    input logic               o_empty,
    input logic               i_pop,
    input logic signed [15:0] o_rect_left,
    input logic signed [15:0] o_rect_top,
    input logic [15:0]        o_rect_width,
    input logic [15:0]        o_rect_height,
    input logic [23:0]        o_rect_ink,
    input logic               o_last_rect
);

    // Reset leaves no result waiting
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    // Reset leaves room for new items
    a_rst_room: assert property (@(posedge i_clk) !i_rst_n |=> !o_full)
        else $error("input side full after reset");

    // Rectangle height is the effective scale, never zero
    a_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_rect_height != 16'd0 && o_rect_height <= 16'd15))
        else $error("rectangle height out of range");

    // A waiting rectangle holds while the consumer stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_rect_left)
            && $stable(o_rect_top) && $stable(o_rect_width)
            && $stable(o_rect_ink) && $stable(o_last_rect)))
        else $error("stalled rectangle changed");

endmodule

bind underline_rect_generator urg_checker u_urg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_full        (o_full),
    .o_empty       (o_empty),
    .i_pop         (i_pop),
    .o_rect_left   (o_rect_left),
    .o_rect_top    (o_rect_top),
    .o_rect_width  (o_rect_width),
    .o_rect_height (o_rect_height),
    .o_rect_ink    (o_rect_ink),
    .o_last_rect   (o_last_rect)
);
